[hdl/led_pkg.sv]
// Package for the lower envelope deque: sizes, command and status codes.
// No dependencies; every other file of the block depends on it.
package led_pkg;

   localparam int DEPTH    = 1024;
   localparam int CW       = 32;
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int XW       = CW + 2;
   localparam int CVW      = XW + 1;
   localparam int EVW      = 2 * CW + 3;
   localparam int VW       = 2 * CW;
   localparam int DIV_W    = CW + 1;
   localparam int QUO_W    = CW + 2;
   localparam int CSR_AW   = 1;
   localparam int STAT_W   = 2;
   localparam int CMD_W    = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_GET        = 3'd4,
      CMD_CLEAR      = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE      = 2'd0,
      ST_DISCARDED = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   localparam logic [CSR_AW-1:0] CSR_INIT_LOW  = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_INIT_HIGH = 1'b1;

endpackage

[hdl/led_if.sv]
// Handshake channel interfaces of the lower envelope deque.
// Depends on led_pkg for field widths.
interface led_req_if;
   logic                              valid;
   logic                              ready;
   logic [led_pkg::CMD_W-1:0]         cmd;
   logic signed [led_pkg::CW-1:0]     line_slope;
   logic signed [led_pkg::CW-1:0]     line_intercept;
   logic signed [led_pkg::CW-1:0]     query_x;
   modport source (output valid, cmd, line_slope, line_intercept, query_x, input ready);
   modport sink (input valid, cmd, line_slope, line_intercept, query_x, output ready);
endinterface

interface led_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [led_pkg::STAT_W-1:0]        status;
   logic signed [led_pkg::CW-1:0]     best_slope;
   logic signed [led_pkg::CW-1:0]     best_intercept;
   logic signed [led_pkg::VW-1:0]     best_value;
   logic [led_pkg::CNT_W-1:0]         line_count;
   modport source (output valid, status, best_slope, best_intercept, best_value, line_count,
                   input ready);
   modport sink (input valid, status, best_slope, best_intercept, best_value, line_count,
                 output ready);
endinterface

interface led_csr_if;
   logic                              valid;
   logic                              ready;
   logic [led_pkg::CSR_AW-1:0]        addr;
   logic [led_pkg::CW-1:0]            data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

[hdl/lower_envelope_deque_top.sv]
// Top level of the lower envelope deque: command sequencer, bounds and result register.
// Depends on led_pkg, led_if, led_ring, led_mac and led_div.
//
// This block keeps the lower envelope of lines y = a*x + b in a ring store of
// DEPTH entries and takes one command at a time: it drops ready after each
// accepted transfer and raises it again once the result is in its output
// register, so the next command can enter while that result waits. A command
// runs on a small sequencer around one evaluation unit (a registered 32x34
// multiply-add) and one iterative floor divider. A get runs a binary search
// over the lines; a pop tests and trims lines one at a time; a push runs the
// discard test and then examines lines one at a time, dividing out the
// intersection of two lines when their slopes differ. Clear and unused
// commands go straight to the result. The store needs no clearing after
// reset. Configuration writes are always accepted and should be made while no
// command is in flight; they take effect on the next clear.
module lower_envelope_deque_top (
   input  logic      clock,
   input  logic      reset,
   led_req_if.sink   req_bus,
   led_rsp_if.source rsp_bus,
   led_csr_if.sink   csr_bus
);
   import led_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_START    = 13'b0000000000010,
      S_LOOP     = 13'b0000000000100,
      S_READ_P   = 13'b0000000001000,
      S_READ_Q   = 13'b0000000010000,
      S_CAPT_Q   = 13'b0000000100000,
      S_XSEL     = 13'b0000001000000,
      S_DIV      = 13'b0000010000000,
      S_EVAL_L   = 13'b0000100000000,
      S_EVAL_R   = 13'b0001000000000,
      S_DECIDE   = 13'b0010000000000,
      S_PUSH_END = 13'b0100000000000,
      S_DONE     = 13'b1000000000000
   } state_type;

   localparam logic signed [CVW-1:0] CV_ONE = CVW'(1);

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic signed [CW-1:0] la_ff, la_in, lb_ff, lb_in, qx_ff, qx_in;
   logic [PTR_W-1:0]     front_ff, front_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic signed [CW-1:0] dlow_ff, dlow_in, dhigh_ff, dhigh_in;
   logic [CW-1:0]        initl_ff, initl_in, inith_ff, inith_in;
   logic [CNT_W-1:0]     f_ff, f_in, n_ff, n_in, lo_ff, lo_in, hi_ff, hi_in;
   logic                 disc_ff, disc_in, final_ff, final_in;
   logic signed [CW-1:0] pa_ff, pa_in, pb_ff, pb_in, qa_ff, qa_in, qb_ff, qb_in;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [EVW-1:0] evl_ff, evl_in;
   status_type           stat_ff, stat_in;
   logic signed [CW-1:0] ba_ff, ba_in, bb_ff, bb_in;
   logic signed [VW-1:0] bv_ff, bv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]    o_stat_ff, o_stat_in;
   logic signed [CW-1:0] o_a_ff, o_a_in, o_b_ff, o_b_in;
   logic signed [VW-1:0] o_v_ff, o_v_in;
   logic [CNT_W-1:0]     o_cnt_ff, o_cnt_in;

   logic [CNT_W-1:0]     idx_p, idx_q;
   logic [CNT_W:0]       md_sum;
   logic [CNT_W-1:0]     md;
   logic [PTR_W-1:0]     addr_p, addr_q, new_front, back_addr;
   logic [CNT_W:0]       front_sum;
   logic                 need_cross;
   logic signed [CW-1:0] l_a, l_b, r_a, r_b, mac_a, mac_b;
   logic signed [EVW-1:0] mac_out;
   logic                 lt, gt;
   logic                 div_start, div_done;
   logic signed [QUO_W-1:0] quo;
   logic signed [CVW-1:0] cv_div, cv_eq, cv_pick;
   logic signed [XW-1:0]  x_src;
   logic                 ring_we, ring_re;
   logic [PTR_W-1:0]     ring_raddr;
   logic [2*CW-1:0]      ring_rdata;

   // Ring address of a logical position counted from the front line.
   function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] idx);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(base) + (CNT_W+1)'(idx);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   // Positions of the two lines read in this round.
   always_comb begin
      md_sum = (CNT_W+1)'(lo_ff) + (CNT_W+1)'(hi_ff);
      md     = md_sum[CNT_W:1];
      idx_p  = '0;
      idx_q  = '0;
      case (cmd_ff)
         CMD_PUSH_FRONT: begin
            idx_p = disc_ff ? '0 : f_ff;
            idx_q = disc_ff ? '0 : f_ff + CNT_W'(1);
         end
         CMD_PUSH_BACK: begin
            if (disc_ff) begin
               idx_p = count_ff - CNT_W'(1);
               idx_q = count_ff - CNT_W'(1);
            end else if (n_ff > CNT_W'(1)) begin
               idx_p = n_ff - CNT_W'(2);
               idx_q = n_ff - CNT_W'(1);
            end
         end
         CMD_POP_FRONT: begin
            idx_q = CNT_W'(1);
         end
         CMD_POP_BACK: begin
            idx_p = count_ff - CNT_W'(2);
            idx_q = count_ff - CNT_W'(1);
         end
         CMD_GET: begin
            idx_p = final_ff ? lo_ff : md;
            idx_q = final_ff ? lo_ff : md + CNT_W'(1);
         end
         default: begin
            idx_p = '0;
         end
      endcase
   end

   assign addr_p    = ring_addr(front_ff, idx_p);
   assign addr_q    = ring_addr(front_ff, idx_q);
   assign back_addr = ring_addr(front_ff, n_ff);

   // A front push lands one slot ahead of the first line it keeps.
   always_comb begin
      front_sum = (CNT_W+1)'(front_ff) + (CNT_W+1)'(f_ff);
      if (front_sum >= (CNT_W+1)'(DEPTH)) begin
         front_sum = front_sum - (CNT_W+1)'(DEPTH);
      end
      new_front = (front_sum == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(front_sum - (CNT_W+1)'(1));
   end

   assign need_cross = !disc_ff && (cmd_ff == CMD_PUSH_FRONT || cmd_ff == CMD_PUSH_BACK)
                       && (n_ff > CNT_W'(1));

   // Left and right sides of the comparison.
   always_comb begin
      if (!disc_ff && (cmd_ff == CMD_PUSH_FRONT || cmd_ff == CMD_PUSH_BACK)) begin
         l_a = la_ff;
         l_b = lb_ff;
      end else begin
         l_a = pa_ff;
         l_b = pb_ff;
      end
      if (disc_ff) begin
         r_a = la_ff;
         r_b = lb_ff;
      end else if (cmd_ff == CMD_PUSH_FRONT) begin
         r_a = pa_ff;
         r_b = pb_ff;
      end else begin
         r_a = qa_ff;
         r_b = qb_ff;
      end
      mac_a = (state_ff == S_EVAL_L) ? l_a : r_a;
      mac_b = (state_ff == S_EVAL_L) ? l_b : r_b;
   end

   assign lt = evl_ff < mac_out;
   assign gt = evl_ff > mac_out;

   // Evaluation point when no intersection is needed.
   always_comb begin
      case (cmd_ff)
         CMD_PUSH_FRONT: x_src = disc_ff ? XW'(dlow_ff) : XW'(dhigh_ff);
         CMD_PUSH_BACK:  x_src = disc_ff ? XW'(dhigh_ff) : XW'(dlow_ff);
         CMD_POP_FRONT:  x_src = XW'(dlow_ff);
         CMD_POP_BACK:   x_src = XW'(dhigh_ff);
         default:        x_src = XW'(qx_ff);
      endcase
   end

   // First point where the later line wins; equal slopes are settled by intercept.
   always_comb begin
      cv_eq  = (pb_ff < qb_ff) ? CVW'(dhigh_ff) + CV_ONE : CVW'(dlow_ff);
      cv_div = CVW'(quo) + CV_ONE;
      if (cv_div < CVW'(dlow_ff)) begin
         cv_div = CVW'(dlow_ff);
      end
      if (cv_div > CVW'(dhigh_ff) + CV_ONE) begin
         cv_div = CVW'(dhigh_ff) + CV_ONE;
      end
      cv_pick = (state_ff == S_DIV) ? cv_div : cv_eq;
      if (cmd_ff == CMD_PUSH_FRONT) begin
         cv_pick = cv_pick - CV_ONE;
      end
   end

   assign div_start = (state_ff == S_XSEL) && need_cross && (pa_ff != qa_ff);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      la_in    = la_ff;
      lb_in    = lb_ff;
      qx_in    = qx_ff;
      front_in = front_ff;
      count_in = count_ff;
      dlow_in  = dlow_ff;
      dhigh_in = dhigh_ff;
      initl_in = initl_ff;
      inith_in = inith_ff;
      f_in     = f_ff;
      n_in     = n_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      disc_in  = disc_ff;
      final_in = final_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      qa_in    = qa_ff;
      qb_in    = qb_ff;
      x_in     = x_ff;
      evl_in   = evl_ff;
      stat_in  = stat_ff;
      ba_in    = ba_ff;
      bb_in    = bb_ff;
      bv_in    = bv_ff;
      ring_we  = 1'b0;
      ring_re  = 1'b0;
      ring_raddr = addr_p;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      o_stat_in = o_stat_ff;
      o_a_in    = o_a_ff;
      o_b_in    = o_b_ff;
      o_v_in    = o_v_ff;
      o_cnt_in  = o_cnt_ff;

      if (csr_bus.valid) begin
         if (csr_bus.addr == CSR_INIT_LOW) begin
            initl_in = csr_bus.data;
         end else if (csr_bus.addr == CSR_INIT_HIGH) begin
            inith_in = csr_bus.data;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               cmd_in   = cmd_type'(req_bus.cmd);
               la_in    = req_bus.line_slope;
               lb_in    = req_bus.line_intercept;
               qx_in    = req_bus.query_x;
               stat_in  = ST_DONE;
               ba_in    = '0;
               bb_in    = '0;
               bv_in    = '0;
               disc_in  = 1'b0;
               final_in = 1'b0;
               state_in = S_START;
            end
         end
         S_START: begin
            f_in     = '0;
            n_in     = count_ff;
            state_in = S_LOOP;
            case (cmd_ff)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (count_ff != '0) begin
                     disc_in  = 1'b1;
                     state_in = S_READ_P;
                  end else begin
                     state_in = S_PUSH_END;
                  end
               end
               CMD_POP_FRONT: dlow_in = qx_ff;
               CMD_POP_BACK:  dhigh_in = qx_ff;
               CMD_GET: begin
                  if (count_ff == '0) begin
                     stat_in  = ST_EMPTY;
                     state_in = S_DONE;
                  end else begin
                     lo_in = '0;
                     hi_in = count_ff - CNT_W'(1);
                  end
               end
               CMD_CLEAR: begin
                  dlow_in  = initl_ff;
                  dhigh_in = inith_ff;
                  count_in = '0;
                  front_in = '0;
                  state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_LOOP: begin
            case (cmd_ff)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  state_in = (n_ff == '0) ? S_PUSH_END : S_READ_P;
               end
               CMD_POP_FRONT, CMD_POP_BACK: begin
                  state_in = (count_ff > CNT_W'(1)) ? S_READ_P : S_DONE;
               end
               CMD_GET: begin
                  final_in = !(lo_ff < hi_ff);
                  state_in = S_READ_P;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_READ_P: begin
            ring_re    = 1'b1;
            ring_raddr = addr_p;
            state_in   = S_READ_Q;
         end
         S_READ_Q: begin
            ring_re    = 1'b1;
            ring_raddr = addr_q;
            pa_in      = ring_rdata[2*CW-1:CW];
            pb_in      = ring_rdata[CW-1:0];
            state_in   = S_CAPT_Q;
         end
         S_CAPT_Q: begin
            qa_in    = ring_rdata[2*CW-1:CW];
            qb_in    = ring_rdata[CW-1:0];
            state_in = S_XSEL;
         end
         S_XSEL: begin
            if (!need_cross) begin
               x_in     = x_src;
               state_in = S_EVAL_L;
            end else if (pa_ff == qa_ff) begin
               x_in     = XW'(cv_pick);
               state_in = S_EVAL_L;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               x_in     = XW'(cv_pick);
               state_in = S_EVAL_L;
            end
         end
         S_EVAL_L: begin
            state_in = S_EVAL_R;
         end
         S_EVAL_R: begin
            evl_in   = mac_out;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_LOOP;
            case (cmd_ff)
               CMD_PUSH_FRONT: begin
                  if (disc_ff) begin
                     disc_in = 1'b0;
                     if (lt) begin
                        stat_in  = ST_DISCARDED;
                        state_in = S_DONE;
                     end
                  end else if (gt) begin
                     state_in = S_PUSH_END;
                  end else begin
                     f_in = f_ff + CNT_W'(1);
                     n_in = n_ff - CNT_W'(1);
                  end
               end
               CMD_PUSH_BACK: begin
                  if (disc_ff) begin
                     disc_in = 1'b0;
                     if (!gt) begin
                        stat_in  = ST_DISCARDED;
                        state_in = S_DONE;
                     end
                  end else if (!lt) begin
                     state_in = S_PUSH_END;
                  end else begin
                     n_in = n_ff - CNT_W'(1);
                  end
               end
               CMD_POP_FRONT: begin
                  if (gt) begin
                     front_in = ring_addr(front_ff, CNT_W'(1));
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     state_in = S_DONE;
                  end
               end
               CMD_POP_BACK: begin
                  if (!gt) begin
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     state_in = S_DONE;
                  end
               end
               CMD_GET: begin
                  if (final_ff) begin
                     ba_in    = pa_ff;
                     bb_in    = pb_ff;
                     bv_in    = evl_ff[VW-1:0];
                     state_in = S_DONE;
                  end else if (gt) begin
                     lo_in = md + CNT_W'(1);
                  end else begin
                     hi_in = md;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_PUSH_END: begin
            if (n_ff >= CNT_W'(DEPTH)) begin
               stat_in = ST_FULL;
            end else begin
               ring_we  = 1'b1;
               count_in = n_ff + CNT_W'(1);
               if (cmd_ff == CMD_PUSH_FRONT) begin
                  front_in = new_front;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               o_stat_in    = stat_ff;
               o_a_in       = ba_ff;
               o_b_in       = bb_ff;
               o_v_in       = bv_ff;
               o_cnt_in     = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         dlow_ff      <= {1'b1, {(CW-1){1'b0}}};
         dhigh_ff     <= {1'b0, {(CW-1){1'b1}}};
         initl_ff     <= {1'b1, {(CW-1){1'b0}}};
         inith_ff     <= {1'b0, {(CW-1){1'b1}}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         dlow_ff      <= dlow_in;
         dhigh_ff     <= dhigh_in;
         initl_ff     <= initl_in;
         inith_ff     <= inith_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      la_ff    <= la_in;
      lb_ff    <= lb_in;
      qx_ff    <= qx_in;
      f_ff     <= f_in;
      n_ff     <= n_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      disc_ff  <= disc_in;
      final_ff <= final_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      qa_ff    <= qa_in;
      qb_ff    <= qb_in;
      x_ff     <= x_in;
      evl_ff   <= evl_in;
      stat_ff  <= stat_in;
      ba_ff    <= ba_in;
      bb_ff    <= bb_in;
      bv_ff    <= bv_in;
      o_stat_ff <= o_stat_in;
      o_a_ff    <= o_a_in;
      o_b_ff    <= o_b_in;
      o_v_ff    <= o_v_in;
      o_cnt_ff  <= o_cnt_in;
   end

   led_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr ((cmd_ff == CMD_PUSH_FRONT) ? new_front : back_addr),
      .wr_data ({la_ff, lb_ff}),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   led_mac u_mac (
      .clock (clock),
      .slope (mac_a),
      .x     (x_ff),
      .icpt  (mac_b),
      .value (mac_out)
   );

   led_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (DIV_W'(qb_ff) - DIV_W'(pb_ff)),
      .den   (DIV_W'(pa_ff) - DIV_W'(qa_ff)),
      .done  (div_done),
      .quo   (quo)
   );

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign csr_bus.ready          = 1'b1;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = o_stat_ff;
   assign rsp_bus.best_slope     = o_a_ff;
   assign rsp_bus.best_intercept = o_b_ff;
   assign rsp_bus.best_value     = o_v_ff;
   assign rsp_bus.line_count     = o_cnt_ff;
endmodule

[hdl/led_ring.sv]
// Line store of the deque: one write port, one registered read port.
// Depends on led_pkg for depth and widths.
module led_ring (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [led_pkg::PTR_W-1:0]      wr_addr,
   input  logic [2*led_pkg::CW-1:0]       wr_data,
   input  logic                           rd_en,
   input  logic [led_pkg::PTR_W-1:0]      rd_addr,
   output logic [2*led_pkg::CW-1:0]       rd_data
);
   import led_pkg::*;

   logic [2*CW-1:0] mem [DEPTH];
   logic [2*CW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/led_mac.sv]
// Shared evaluation unit: registered a*x + b at full precision.
// Depends on led_pkg for widths.
module led_mac (
   input  logic                             clock,
   input  logic signed [led_pkg::CW-1:0]    slope,
   input  logic signed [led_pkg::XW-1:0]    x,
   input  logic signed [led_pkg::CW-1:0]    icpt,
   output logic signed [led_pkg::EVW-1:0]   value
);
   import led_pkg::*;

   logic signed [CW+XW-1:0] prod;
   logic signed [EVW-1:0]   value_ff;

   assign prod = slope * x;

   always_ff @(posedge clock) begin
      value_ff <= EVW'(prod) + EVW'(icpt);
   end

   assign value = value_ff;
endmodule

[hdl/led_div.sv]
// Iterative signed floor divider, one quotient bit per cycle.
// Depends on led_pkg for widths.
module led_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [led_pkg::DIV_W-1:0]   num,
   input  logic signed [led_pkg::DIV_W-1:0]   den,
   output logic                               done,
   output logic signed [led_pkg::QUO_W-1:0]   quo
);
   import led_pkg::*;

   localparam int CNTW = $clog2(DIV_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]  qm_ff, qm_in;
   logic [DIV_W-1:0]  rm_ff, rm_in;
   logic [DIV_W-1:0]  dm_ff, dm_in;
   logic              neg_ff, neg_in;
   logic [DIV_W:0]    trial;
   logic signed [QUO_W-1:0] qpos;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      qm_in   = qm_ff;
      rm_in   = rm_ff;
      dm_in   = dm_ff;
      neg_in  = neg_ff;
      trial   = {rm_ff, qm_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(DIV_W);
         qm_in   = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
         dm_in   = den[DIV_W-1] ? DIV_W'(-den) : DIV_W'(den);
         rm_in   = '0;
         neg_in  = num[DIV_W-1] ^ den[DIV_W-1];
      end else if (busy_ff) begin
         if (trial >= {1'b0, dm_ff}) begin
            rm_in = DIV_W'(trial - {1'b0, dm_ff});
            qm_in = {qm_ff[DIV_W-2:0], 1'b1};
         end else begin
            rm_in = trial[DIV_W-1:0];
            qm_in = {qm_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      qm_ff  <= qm_in;
      rm_ff  <= rm_in;
      dm_ff  <= dm_in;
      neg_ff <= neg_in;
   end

   // Truncated quotient toward zero, then moved down one when signs differ and
   // the remainder is nonzero.
   assign qpos = QUO_W'({1'b0, qm_ff});
   always_comb begin
      if (!neg_ff) begin
         quo = qpos;
      end else if (rm_ff != '0) begin
         quo = -qpos - QUO_W'(1);
      end else begin
         quo = -qpos;
      end
   end
   assign done = done_ff;
endmodule

[dv/tb_pkg.sv]
// Shared testbench types for the lower envelope deque bench: a command record and an answer record.
// Depends on led_pkg for widths and command codes.
package tb_pkg;
   import led_pkg::*;

   typedef struct {
      cmd_type               cmd;
      logic signed [CW-1:0]  slope;
      logic signed [CW-1:0]  icpt;
      logic signed [CW-1:0]  qx;
   } command_t;

   typedef struct {
      status_type            status;
      logic signed [CW-1:0]  slope;
      logic signed [CW-1:0]  icpt;
      logic signed [VW-1:0]  value;
      logic [CNT_W-1:0]      count;
   } answer_t;
endpackage

[dv/tb_top.sv]
// Self-checking bench for lower_envelope_deque_top: random and directed deque commands,
// predicted in place by a line-envelope model. Depends on led_pkg, led_if, tb_pkg, the RTL.
module tb_top;
   import led_pkg::*;
   import tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   led_req_if req_bus ();
   led_rsp_if rsp_bus ();
   led_csr_if csr_bus ();

   lower_envelope_deque_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always #6 clock = ~clock;

   // Predictor state: the ring of lines, the deque pointers, the domain and the
   // two configuration registers that a clear copies into the domain.
   logic signed [CW-1:0] ring_slope [DEPTH];
   logic signed [CW-1:0] ring_icpt [DEPTH];
   int unsigned          head_ptr;
   int unsigned          held;
   longint               dom_low, dom_high;
   logic signed [CW-1:0] cfg_low, cfg_high;

   command_t pending_cmds [$];
   answer_t  awaited [$];
   int       errors = 0;
   longint   cycles = 0;
   bit       stim_done = 1'b0;
   bit       hold_sender = 1'b0;
   int       send_gap = 0;
   int       take_gap = 0;

   task automatic report(input string what);
      errors++;
      $display("tb_top: mismatch: %s", what);
   endtask

   function automatic longint slope_of(int unsigned i);
      return longint'(ring_slope[(head_ptr + i) % DEPTH]);
   endfunction

   function automatic longint icpt_of(int unsigned i);
      return longint'(ring_icpt[(head_ptr + i) % DEPTH]);
   endfunction

   function automatic longint line_value(int unsigned i, longint x);
      return slope_of(i) * x + icpt_of(i);
   endfunction

   function automatic longint div_floor(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d != 0) && ((n < 0) != (d < 0))) q--;
      return q;
   endfunction

   // First x at which line j strictly undercuts line i, clamped to the domain.
   function automatic longint crossing(int unsigned i, int unsigned j);
      longint a, b, oa, ob, v;
      a = slope_of(i); b = icpt_of(i); oa = slope_of(j); ob = icpt_of(j);
      if (a == oa) return (b < ob) ? dom_high + 1 : dom_low;
      v = div_floor(ob - b, a - oa) + 1;
      if (v < dom_low) v = dom_low;
      if (v > dom_high + 1) v = dom_high + 1;
      return v;
   endfunction

   function automatic answer_t envelope_step(command_t c);
      answer_t      r;
      longint       la, lb, qx, x;
      int unsigned  f, n, lo, hi, md;
      la = longint'(c.slope); lb = longint'(c.icpt); qx = longint'(c.qx);
      r.status = ST_DONE; r.slope = '0; r.icpt = '0; r.value = '0;
      case (c.cmd)
         CMD_PUSH_FRONT: begin
            if (held != 0 && line_value(0, dom_low) < la * dom_low + lb) begin
               r.status = ST_DISCARDED;
            end else begin
               f = 0; n = held;
               while (n != 0) begin
                  x = (n <= 1) ? dom_high : crossing(f, f + 1) - 1;
                  if (la * x + lb > line_value(f, x)) break;
                  f++; n--;
               end
               if (n >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  head_ptr = (head_ptr + f + DEPTH - 1) % DEPTH;
                  ring_slope[head_ptr] = c.slope;
                  ring_icpt[head_ptr] = c.icpt;
                  held = n + 1;
               end
            end
         end
         CMD_PUSH_BACK: begin
            if (held != 0 && line_value(held - 1, dom_high) <= la * dom_high + lb) begin
               r.status = ST_DISCARDED;
            end else begin
               n = held;
               while (n != 0) begin
                  x = (n <= 1) ? dom_low : crossing(n - 2, n - 1);
                  if (la * x + lb >= line_value(n - 1, x)) break;
                  n--;
               end
               if (n >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  ring_slope[(head_ptr + n) % DEPTH] = c.slope;
                  ring_icpt[(head_ptr + n) % DEPTH] = c.icpt;
                  held = n + 1;
               end
            end
         end
         CMD_POP_FRONT: begin
            dom_low = qx;
            while (held > 1 && line_value(0, dom_low) > line_value(1, dom_low)) begin
               head_ptr = (head_ptr + 1) % DEPTH;
               held--;
            end
         end
         CMD_POP_BACK: begin
            dom_high = qx;
            while (held > 1 && line_value(held - 2, dom_high) <= line_value(held - 1, dom_high))
               held--;
         end
         CMD_GET: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               lo = 0; hi = held - 1;
               while (lo < hi) begin
                  md = (lo + hi) / 2;
                  if (line_value(md, qx) > line_value(md + 1, qx)) lo = md + 1;
                  else hi = md;
               end
               r.slope = ring_slope[(head_ptr + lo) % DEPTH];
               r.icpt = ring_icpt[(head_ptr + lo) % DEPTH];
               r.value = slope_of(lo) * qx + icpt_of(lo);
            end
         end
         CMD_CLEAR: begin
            dom_low = longint'(cfg_low);
            dom_high = longint'(cfg_high);
            held = 0;
            head_ptr = 0;
         end
         default: ;
      endcase
      r.count = held[CNT_W-1:0];
      return r;
   endfunction

   // Driver: presents the oldest pending command after a random gap and
   // predicts its answer on the accepting edge.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= $urandom_range(0, 15);
      end else if (req_bus.valid && req_bus.ready) begin
         awaited.push_back(envelope_step(pending_cmds.pop_front()));
         req_bus.valid <= 1'b0;
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end else if (!req_bus.valid && !hold_sender && pending_cmds.size() != 0) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
         end else begin
            req_bus.valid <= 1'b1;
            req_bus.cmd <= pending_cmds[0].cmd;
            req_bus.line_slope <= pending_cmds[0].slope;
            req_bus.line_intercept <= pending_cmds[0].icpt;
            req_bus.query_x <= pending_cmds[0].qx;
         end
      end
   end

   // Monitor: random stalls on the result side, and each transfer is compared
   // with the oldest prediction field by field.
   always @(posedge clock) begin
      answer_t e;
      cycles <= cycles + 1;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_gap <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited.size() == 0) begin
               report("result with nothing expected");
            end else begin
               e = awaited.pop_front();
               if (rsp_bus.status !== e.status)
                  report($sformatf("status %0d, want %0d", rsp_bus.status, e.status));
               if (rsp_bus.best_slope !== e.slope)
                  report($sformatf("slope %0d, want %0d", rsp_bus.best_slope, e.slope));
               if (rsp_bus.best_intercept !== e.icpt)
                  report($sformatf("intercept %0d, want %0d", rsp_bus.best_intercept, e.icpt));
               if (rsp_bus.best_value !== e.value)
                  report($sformatf("value %0d, want %0d", rsp_bus.best_value, e.value));
               if (rsp_bus.line_count !== e.count)
                  report($sformatf("count %0d, want %0d", rsp_bus.line_count, e.count));
            end
            rsp_bus.ready <= 1'b0;
            take_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         end else if (!rsp_bus.ready) begin
            if (take_gap != 0) take_gap <= take_gap - 1;
            else rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run and reports errors once the cycle count passes its bound.
   always @(posedge clock) begin
      if (cycles > 3000000) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic command_t make_cmd(cmd_type c, longint a, longint b, longint x);
      command_t k;
      k.cmd = c; k.slope = a[CW-1:0]; k.icpt = b[CW-1:0]; k.qx = x[CW-1:0];
      return k;
   endfunction

   function automatic logic [CW-1:0] any_word();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return {{(CW-8){1'b0}}, 8'($urandom)} - 32'd128;
         2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom_range(0, 40) - 20;
      endcase
   endfunction

   task automatic wait_drained(int settle);
      while (pending_cmds.size() != 0 || awaited.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_AW-1:0] idx, logic [CW-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.addr <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_INIT_LOW) cfg_low = val;
      else cfg_high = val;
   endtask

   // One session: clear, a run of pushes in slope order with occasional gets, pops
   // and random commands, random content, small coordinates mostly.
   task automatic session(int len, bit wide);
      longint s;
      int     dir;
      cmd_type p;
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0));
      dir = $urandom_range(0, 1);
      s = wide ? -2147483648 : -500;
      if (dir == 0) s = wide ? 2147483647 - 3000 : 500;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0, 1: pending_cmds.push_back(make_cmd(CMD_GET, 0, 0,
                     wide ? longint'(signed'(any_word())) : $urandom_range(0, 2000) - 1000));
            2: begin
               p = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
               pending_cmds.push_back(make_cmd(p, 0, 0,
                  (p == CMD_POP_FRONT) ? -1000 + $urandom_range(0, 300) :
                                         1000 - $urandom_range(0, 300)));
            end
            3: pending_cmds.push_back(make_cmd(cmd_type'($urandom_range(0, 7)),
                  signed'(any_word()), signed'(any_word()), signed'(any_word())));
            default: begin
               s = (dir == 0) ? s - $urandom_range(0, 3) : s + $urandom_range(0, 3);
               pending_cmds.push_back(make_cmd(dir ? CMD_PUSH_FRONT : CMD_PUSH_BACK, s,
                  wide ? longint'(signed'(any_word())) : $urandom_range(0, 4000) - 2000, 0));
            end
         endcase
      end
   endtask

   initial begin
      int budget;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_CLEAR;
      req_bus.line_slope = '0;
      req_bus.line_intercept = '0;
      req_bus.query_x = '0;
      csr_bus.valid = 1'b0;
      csr_bus.addr = CSR_INIT_LOW;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      head_ptr = 0; held = 0;
      cfg_low = 32'sh80000000; cfg_high = 32'sh7fffffff;
      dom_low = longint'(cfg_low); dom_high = longint'(cfg_high);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty get, extremes of every field, equal slopes, discards,
      // unused commands, pops on an empty store and crossed bounds.
      pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_POP_FRONT, 0, 0, 5));
      pending_cmds.push_back(make_cmd(CMD_PUSH_BACK, 2147483647, -2147483648, 0));
      pending_cmds.push_back(make_cmd(CMD_PUSH_BACK, 2147483647, -2147483648, 0));
      pending_cmds.push_back(make_cmd(CMD_PUSH_BACK, 0, 7, 0));
      pending_cmds.push_back(make_cmd(CMD_PUSH_BACK, -2147483648, 2147483647, 0));
      pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, -2147483648));
      pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, 2147483647));
      pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_PUSH_FRONT, 2147483647, 2147483647, 0));
      pending_cmds.push_back(make_cmd(CMD_PUSH_FRONT, 2147483647, -2147483648, 0));
      pending_cmds.push_back(make_cmd(cmd_type'(6), -1, -1, -1));
      pending_cmds.push_back(make_cmd(cmd_type'(7), 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_POP_FRONT, 0, 0, 100));
      pending_cmds.push_back(make_cmd(CMD_POP_BACK, 0, 0, -100));
      pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, 3));
      pending_cmds.push_back(make_cmd(CMD_PUSH_BACK, 3, 4, 0));
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_POP_BACK, 0, 0, 2147483647));
      pending_cmds.push_back(make_cmd(CMD_POP_FRONT, 0, 0, -2147483648));
      wait_drained(20);

      // Fill the store to its depth so that a full refusal is seen.
      write_reg(CSR_INIT_LOW, 32'sd0);
      write_reg(CSR_INIT_HIGH, 32'sd2000000);
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0));
      for (int i = 0; i <= DEPTH; i++)
         pending_cmds.push_back(make_cmd(CMD_PUSH_BACK, -i, i * (i - 1) / 2, 0));
      pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, 500));
      wait_drained(20);

      // Random sessions across several domain settings, extremes included.
      budget = 1700;
      while (budget > 0) begin
         case ($urandom_range(0, 4))
            0: begin write_reg(CSR_INIT_LOW, 32'h80000000); write_reg(CSR_INIT_HIGH, 32'h7fffffff); end
            1: begin write_reg(CSR_INIT_LOW, -1000); write_reg(CSR_INIT_HIGH, 1000); end
            2: begin write_reg(CSR_INIT_LOW, $urandom); write_reg(CSR_INIT_HIGH, $urandom); end
            3: begin write_reg(CSR_INIT_LOW, 32'h7fffffff); write_reg(CSR_INIT_HIGH, 32'h80000000); end
            default: begin write_reg(CSR_INIT_LOW, -50); write_reg(CSR_INIT_HIGH, 50); end
         endcase
         session(40, $urandom_range(0, 3) == 0);
         budget -= 41;
         if ($urandom_range(0, 2) == 0) begin
            // Hold the sender until everything in flight has come back.
            hold_sender = 1'b1;
            while (awaited.size() != 0 || req_bus.valid) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained(20);
      end
      stim_done = 1'b1;
      wait_drained(100);
      if (errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end
endmodule

[files.f]
hdl/led_pkg.sv
hdl/led_if.sv
hdl/led_ring.sv
hdl/led_mac.sv
hdl/led_div.sv
hdl/lower_envelope_deque_top.sv
dv/tb_pkg.sv
dv/tb_top.sv
